/* sv/gb3_pkg.sv */
// Package for the 3x3 Gaussian blur stream: widths, register codes, kernel,
// stage control types and the weighted-sum function.
// No dependencies; every other file of the block but gb3_line_mem uses it.
`default_nettype none

package gb3_pkg;

  // Field and register widths.
  localparam int PIX_W         = 8;
  localparam int DIM_W         = 11;
  localparam int ROW_W         = 10;
  localparam int SUM_W         = 12;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  // Frame geometry limits and reset values.
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int HEIGHT_MAX    = 1024;
  localparam int DIM_MIN       = 3;
  localparam int DIM_RESET     = 512;
  localparam int WIN_N         = 3;

  // Output queue depth covers the two pipeline stages plus two waiting words.
  localparam int FIFO_DEPTH    = 4;

  // Register index, taken from the word address.
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } gb3_reg_t;

  // Blur kernel 1 2 1 / 2 4 2 / 1 2 1.
  localparam logic [2:0] KERNEL [WIN_N][WIN_N] = '{
    '{3'd1, 3'd2, 3'd1},
    '{3'd2, 3'd4, 3'd2},
    '{3'd1, 3'd2, 3'd1}
  };

  typedef logic [PIX_W-1:0] gb3_pix_t;

  // Window entry [row*3 + col], row 0 is the oldest row.
  typedef gb3_pix_t [8:0] gb3_win_t;

  // Control that travels with a word through the pipeline.
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } gb3_ctl_t;

  // A finished result word.
  typedef struct packed {
    logic     valid;
    logic     last;
    gb3_pix_t pixel;
  } gb3_res_t;

  // Weighted nine-tap sum; the maximum is 16 * 255 = 4080, so it fits 12 bits.
  function automatic logic [SUM_W-1:0] blur_sum(input gb3_win_t win);
    logic [SUM_W-1:0] acc;
    acc = SUM_W'(win[0]) * SUM_W'(KERNEL[0][0])
        + SUM_W'(win[1]) * SUM_W'(KERNEL[0][1])
        + SUM_W'(win[2]) * SUM_W'(KERNEL[0][2])
        + SUM_W'(win[3]) * SUM_W'(KERNEL[1][0])
        + SUM_W'(win[4]) * SUM_W'(KERNEL[1][1])
        + SUM_W'(win[5]) * SUM_W'(KERNEL[1][2])
        + SUM_W'(win[6]) * SUM_W'(KERNEL[2][0])
        + SUM_W'(win[7]) * SUM_W'(KERNEL[2][1])
        + SUM_W'(win[8]) * SUM_W'(KERNEL[2][2]);
    return acc;
  endfunction

endpackage

`default_nettype wire

/* sv/gb3_if.sv */
// Valid/ready stream interfaces for the blur block: input pixels and results.
// Depends on gb3_pkg for the pixel width.
`default_nettype none

interface gb3_pixel_in_if;
  logic                       valid;
  logic                       ready;
  logic [gb3_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface gb3_pixel_out_if;
  logic                       valid;
  logic                       ready;
  logic [gb3_pkg::PIX_W-1:0]  pixel_out;
  logic                       frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

/* sv/gb3_line_mem.sv */
// Line store memory: both previous rows packed in one word per column,
// one read and one write port, registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module gb3_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 16,
  parameter int AW     = 10
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [DATA_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Synchronous read; the read data is registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* sv/gb3_window.sv */
// 3x3 neighborhood window and weighted sum. Shifts in one column per word
// and presents the blurred result in the cycle after that word arrives. Depends on gb3_pkg.
`default_nettype none

module gb3_window (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gb3_pkg::gb3_ctl_t ctl_i,
  input  wire gb3_pkg::gb3_pix_t up_i,
  input  wire gb3_pkg::gb3_pix_t mid_i,
  input  wire gb3_pkg::gb3_pix_t pix_i,
  output gb3_pkg::gb3_res_t      res_o,
  output logic                   busy_o
);

  gb3_pkg::gb3_win_t       win_r;
  gb3_pkg::gb3_win_t       win_nxt;
  gb3_pkg::gb3_ctl_t       ctl_r;
  logic [gb3_pkg::SUM_W-1:0] sum;

  // Older columns move left; the new column enters on the right.
  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = up_i;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_i;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = pix_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
      if (ctl_i.valid) begin
        win_r <= win_nxt;
      end
    end
  end

  // Divide by sixteen by dropping the low four bits.
  always_comb begin
    sum          = gb3_pkg::blur_sum(win_r);
    res_o.valid  = ctl_r.valid & ctl_r.emit;
    res_o.last   = ctl_r.last;
    res_o.pixel  = sum[gb3_pkg::SUM_W-1 -: gb3_pkg::PIX_W];
    busy_o       = ctl_r.valid;
  end

endmodule

`default_nettype wire

/* sv/gb3_out_fifo.sv */
// Small output queue that decouples the pipeline from result back-pressure.
// Depends on gb3_pkg and the gb3_pixel_out_if interface.
`default_nettype none

module gb3_out_fifo #(
  parameter int DEPTH = gb3_pkg::FIFO_DEPTH,
  parameter int PW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gb3_pkg::gb3_res_t push_i,
  gb3_pixel_out_if.source        out,
  output logic [CW-1:0]          count_o
);

  gb3_pkg::gb3_res_t mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              pop;

  assign pop = out.valid & out.ready;

  always_comb begin
    count_nxt = count_r + CW'(push_i.valid) - CW'(pop);
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_i.valid) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push_i.valid) begin
      mem_r[wr_ptr_r] <= push_i;
    end
  end

  assign out.valid      = (count_r != '0);
  assign out.pixel_out  = mem_r[rd_ptr_r].pixel;
  assign out.frame_last = mem_r[rd_ptr_r].last;
  assign count_o        = count_r;

endmodule

`default_nettype wire

/* sv/gaussian_blur_3x3_stream.sv */
// Channel   Direction  Handshake          Word
// in_px     in         valid/ready        pixel_in (8 bits, raster order)
// out_px    out        valid/ready        pixel_out (8 bits), frame_last
// cfg_*     in         APB, pready high   image_width @0x0, image_height @0x4
//
// One pixel word is accepted per clock while in_px.ready is high. A result
// passes the line store read, then the window shift and sum, then the output
// queue, which offers it on out_px. The line store memory sets the rate with
// one read and one write per cycle. Reset is synchronous and clears control
// and configuration state and the window; the line stores are not cleared.
// in_px.ready drops while queued plus in-flight words reach four.
//
// Top level of the 3x3 Gaussian blur. Depends on gb3_pkg, gb3_if,
// gb3_line_mem, gb3_window and gb3_out_fifo.
`default_nettype none

module gaussian_blur_3x3_stream #(
  parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  gb3_pixel_in_if.sink                           in_px,
  gb3_pixel_out_if.source                        out_px,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [gb3_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [gb3_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [gb3_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > gb3_pkg::DIM_W) ?
                       $clog2(MAX_WIDTH + 1) : gb3_pkg::DIM_W;
  localparam int DW  = gb3_pkg::DIM_W;
  localparam int RW  = gb3_pkg::ROW_W;
  localparam int PXW = gb3_pkg::PIX_W;
  localparam int QCW = $clog2(gb3_pkg::FIFO_DEPTH + 1);

  // Configuration and position registers.
  logic [DW-1:0]      width_r;
  logic [DW-1:0]      height_r;
  logic [AW-1:0]      col_r;
  logic [RW-1:0]      row_r;

  // Stage one: word whose line store read is in progress.
  gb3_pkg::gb3_ctl_t  ctl1_r;
  gb3_pkg::gb3_pix_t  pix1_r;
  logic [AW-1:0]      col1_r;

  logic [WW-1:0]      w_raw;
  logic [WW-1:0]      w_eff;
  logic [DW-1:0]      h_eff;
  logic [WW-1:0]      col_ext;
  logic [DW-1:0]      row_ext;
  logic               col_wrap;
  logic               row_wrap;
  logic               emit;
  logic               last;
  logic               accept;
  logic               cfg_wr;
  gb3_pkg::gb3_reg_t  cfg_reg;

  logic [2*PXW-1:0]   mem_rd;
  gb3_pkg::gb3_res_t  res;
  logic               win_busy;
  logic [QCW-1:0]     q_count;

  // Clamp the configured frame size to the supported range.
  always_comb begin
    w_raw = WW'(width_r);
    if (w_raw < WW'(gb3_pkg::DIM_MIN)) begin
      w_eff = WW'(gb3_pkg::DIM_MIN);
    end else if (w_raw > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (height_r < DW'(gb3_pkg::DIM_MIN)) begin
      h_eff = DW'(gb3_pkg::DIM_MIN);
    end else if (height_r > DW'(gb3_pkg::HEIGHT_MAX)) begin
      h_eff = DW'(gb3_pkg::HEIGHT_MAX);
    end else begin
      h_eff = height_r;
    end
  end

  // Position decode for the word at the input.
  always_comb begin
    col_ext  = WW'(col_r);
    row_ext  = DW'(row_r);
    col_wrap = (col_ext + 1'b1) >= w_eff;
    row_wrap = (row_ext + 1'b1) >= h_eff;
    emit     = (col_ext >= WW'(gb3_pkg::WIN_N - 1)) &&
               (row_ext >= DW'(gb3_pkg::WIN_N - 1));
    last     = (col_ext == w_eff - 1'b1) && (row_ext == h_eff - 1'b1);
  end

  // Accept only while every word in flight still has a queue slot.
  assign in_px.ready = (q_count + QCW'(ctl1_r.valid) + QCW'(win_busy)) <
                       QCW'(gb3_pkg::FIFO_DEPTH);
  assign accept      = in_px.valid & in_px.ready;

  // Register port decode; the word address selects the register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_reg    = gb3_pkg::gb3_reg_t'(cfg_paddr[2]);

  always_comb begin
    case (cfg_reg)
      gb3_pkg::REG_WIDTH:  cfg_prdata = gb3_pkg::CFG_DATA_W'(width_r);
      gb3_pkg::REG_HEIGHT: cfg_prdata = gb3_pkg::CFG_DATA_W'(height_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // Configuration registers and raster position; a write restarts the frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(gb3_pkg::DIM_RESET);
      height_r <= DW'(gb3_pkg::DIM_RESET);
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg)
        gb3_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[DW-1:0];
        gb3_pkg::REG_HEIGHT: height_r <= cfg_pwdata[DW-1:0];
        default: ;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_r <= '0;
        row_r <= row_wrap ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // Stage one control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r.valid <= accept;
      ctl1_r.emit  <= emit;
      ctl1_r.last  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix1_r <= in_px.pixel_in;
      col1_r <= col_r;
    end
  end

  // Line stores: upper row in the high byte, middle row in the low byte.
  // The write of a column lands at least two words before its next read.
  gb3_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * PXW),
    .AW     (AW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (mem_rd),
    .wr_en   (ctl1_r.valid),
    .wr_addr (col1_r),
    .wr_data ({mem_rd[PXW-1:0], pix1_r})
  );

  gb3_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl1_r),
    .up_i   (mem_rd[2*PXW-1:PXW]),
    .mid_i  (mem_rd[PXW-1:0]),
    .pix_i  (pix1_r),
    .res_o  (res),
    .busy_o (win_busy)
  );

  gb3_out_fifo #(
    .DEPTH (gb3_pkg::FIFO_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (res),
    .out     (out_px),
    .count_o (q_count)
  );

`ifndef SYNTHESIS
  // The raster position always lies inside the clamped frame.
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (col_ext < w_eff) && (row_ext < h_eff))
    else $error("raster position outside the frame");

  // The output queue never holds more words than it has slots.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCW'(gb3_pkg::FIFO_DEPTH))
    else $error("output queue overflow");

  // A word in stage one was accepted on the previous edge.
  a_stage_one_src: assert property (@(posedge clk) disable iff (!rst_n)
    ctl1_r.valid |-> $past(accept))
    else $error("stage one word without an accepted pixel");

  // A result enters the queue only from a word that left stage one.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> $past(ctl1_r.valid && ctl1_r.emit))
    else $error("result without a matching stage one word");
`endif

endmodule

`default_nettype wire
